[rtl/pmst_pkg.sv]
// Package for the peak merge sorted table: codes, states and the word types.
// Depends on nothing; every other file of the block imports it.
package pmst_pkg;

   localparam logic [1:0] MODE_OFFER = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [2:0] CSR_CENTER_X      = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y      = 3'd1;
   localparam logic [2:0] CSR_LIMIT_RADIUS  = 3'd2;
   localparam logic [2:0] CSR_RADIUS_ENABLE = 3'd3;
   localparam logic [2:0] CSR_WINDOW_RADIUS = 3'd4;

   localparam logic [15:0] HITS_MAX     = 16'hFFFF;
   localparam logic [33:0] ONE_PIXEL_SQ = 34'd256;
   localparam int NUM_W = 49;
   localparam int DEN_W = 17;

   typedef enum logic [1:0] {KIND_OFFER, KIND_READ, KIND_CLEAR, KIND_BAD} kind_type;

   typedef enum logic [2:0] {
      ST_MERGED, ST_INSERTED, ST_OUTSIDE, ST_NEAR, ST_FULL, ST_READ, ST_BAD_INDEX, ST_CLEARED
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] x;
      logic [15:0] y;
      logic [31:0] amplitude;
      logic [31:0] integrated;
      logic [5:0]  read_index;
   } cmd_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [31:0] amplitude;
      logic [31:0] integrated;
      logic [15:0] hits;
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  slot;
      logic [5:0]  peak_count;
      entry_type   entry;
   } result_type;

   typedef struct packed {
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [32:0] limit_radius_sq;
      logic        radius_check_enable;
      logic [7:0]  window_radius;
   } cfg_type;

   typedef enum logic [4:0] {
      S_IDLE, S_RD_WAIT, S_RAD_ABS, S_RAD_SQ, S_RAD_SUM, S_RAD_CMP,
      S_SC_RD, S_SC_ABS, S_SC_SQ, S_SC_SUM, S_SC_CMP,
      S_MG_MUL, S_MG_DIV, S_MG_WAIT, S_MG_WRITE,
      S_DECIDE, S_SH_RD, S_SH_WR, S_INS_WR, S_RESP
   } engine_state_type;

endpackage

[rtl/pmst_front.sv]
// Front end: accepts input words, classifies the mode and queues commands.
// Depends on pmst_pkg.
module pmst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [1:0]        mode,
   input  logic [15:0]       peak_x,
   input  logic [15:0]       peak_y,
   input  logic [31:0]       peak_amplitude,
   input  logic [31:0]       peak_integrated,
   input  logic [5:0]        read_index,
   output logic              full,
   output pmst_pkg::cmd_type cmd,
   output logic              cmd_valid,
   input  logic              cmd_pop
);
   import pmst_pkg::*;

   cmd_type    queue_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;
   cmd_type    word;

   always_comb begin
      word.x          = peak_x;
      word.y          = peak_y;
      word.amplitude  = peak_amplitude;
      word.integrated = peak_integrated;
      word.read_index = read_index;
      case (mode)
         MODE_OFFER: word.kind = KIND_OFFER;
         MODE_READ:  word.kind = KIND_READ;
         MODE_CLEAR: word.kind = KIND_CLEAR;
         default:    word.kind = KIND_BAD;
      endcase
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = queue_ff[rd_ff];
   assign push_ok   = push && !full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_in  = push_ok ? !wr_ff : wr_ff;
      rd_in  = pop_ok ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ff] <= word;
      end
   end

endmodule

[rtl/pmst_divider.sv]
// Restoring divider, one quotient bit per cycle, for the running mean.
// Depends on pmst_pkg for the operand widths.
module pmst_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pmst_pkg::NUM_W-1:0] numerator,
   input  logic [pmst_pkg::DEN_W-1:0] denominator,
   output logic                       done,
   output logic [pmst_pkg::NUM_W-1:0] quotient
);
   import pmst_pkg::*;

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   trial;
   logic             bit_set;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      trial   = {rem_ff, q_ff[NUM_W-1]};
      bit_set = (trial >= {1'b0, den_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = '0;
         den_in  = denominator;
         q_in    = numerator;
      end else if (busy_ff) begin
         rem_in = bit_set ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         q_in   = {q_ff[NUM_W-2:0], bit_set};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

[rtl/pmst_engine.sv]
// Back end: table memory and the sequencer for search, merge, insert and read.
// Depends on pmst_pkg and pmst_divider.
module pmst_engine #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pmst_pkg::cfg_type    cfg,
   input  pmst_pkg::cmd_type    cmd,
   input  logic                 cmd_valid,
   output logic                 cmd_pop,
   output pmst_pkg::result_type rsp,
   output logic                 rsp_valid,
   input  logic                 rsp_pop
);
   import pmst_pkg::*;

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CMPW = (AW > 6) ? AW : 6;
   localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

   engine_state_type state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [AW-1:0]    count_ff, count_in, idx_ff, idx_in, ins_ff, ins_in;
   logic             ins_found_ff, ins_found_in;
   entry_type        ent_ff, ent_in, mg_ff, mg_in;
   logic [1:0]       fld_ff, fld_in;
   logic [47:0]      mul_ff, mul_in;
   result_type       res_ff, res_in, out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   logic [15:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0]      sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [33:0]      d_ff, d_in;

   entry_type        table_mem [TABLE_DEPTH];
   entry_type        rdata_ff, wdata;
   logic [AW-1:0]    raddr, waddr;
   logic             we;

   logic [15:0]      ax, ay;
   logic [6:0]       half;
   logic [13:0]      half_sq;
   logic [33:0]      close_thr;
   logic [31:0]      old_sel, val_sel;
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quo;
   logic [DEN_W-1:0] div_den;
   entry_type        new_entry;

   function automatic logic [5:0] low6(logic [AW-1:0] v);
      logic [CMPW-1:0] w;
      w = CMPW'(v);
      return w[5:0];
   endfunction

   pmst_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .numerator  (div_num),
      .denominator(div_den),
      .done       (div_done),
      .quotient   (div_quo)
   );

   always_comb begin
      ax        = (state_ff == S_RAD_ABS) ? cfg.center_x : rdata_ff.x;
      ay        = (state_ff == S_RAD_ABS) ? cfg.center_y : rdata_ff.y;
      dx_in     = (ax > cmd_ff.x) ? ax - cmd_ff.x : cmd_ff.x - ax;
      dy_in     = (ay > cmd_ff.y) ? ay - cmd_ff.y : cmd_ff.y - ay;
      sqx_in    = 32'(dx_ff) * 32'(dx_ff);
      sqy_in    = 32'(dy_ff) * 32'(dy_ff);
      d_in      = 34'(sqx_ff) + 34'(sqy_ff);
      half      = cfg.window_radius[7:1];
      half_sq   = 14'(half) * 14'(half);
      close_thr = 34'({half_sq, 8'h00});
      case (fld_ff)
         2'd0: begin
            old_sel = 32'(ent_ff.x);
            val_sel = 32'(cmd_ff.x);
         end
         2'd1: begin
            old_sel = 32'(ent_ff.y);
            val_sel = 32'(cmd_ff.y);
         end
         2'd2: begin
            old_sel = ent_ff.amplitude;
            val_sel = cmd_ff.amplitude;
         end
         default: begin
            old_sel = ent_ff.integrated;
            val_sel = cmd_ff.integrated;
         end
      endcase
      new_entry.x          = cmd_ff.x;
      new_entry.y          = cmd_ff.y;
      new_entry.amplitude  = cmd_ff.amplitude;
      new_entry.integrated = cmd_ff.integrated;
      new_entry.hits       = 16'd1;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ins_in       = ins_ff;
      ins_found_in = ins_found_ff;
      ent_in       = ent_ff;
      mg_in        = mg_ff;
      fld_in       = fld_ff;
      mul_in       = mul_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      cmd_pop      = 1'b0;
      raddr        = idx_ff;
      waddr        = idx_ff;
      wdata        = rdata_ff;
      we           = 1'b0;
      div_start    = 1'b0;
      div_num      = NUM_W'(mul_ff) + NUM_W'(val_sel);
      div_den      = DEN_W'(ent_ff.hits) + DEN_W'(1);
      case (state_ff)
         S_IDLE: begin
            raddr = AW'(cmd.read_index);
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               res_in  = '0;
               case (cmd.kind)
                  KIND_CLEAR: begin
                     count_in      = '0;
                     res_in.status = ST_CLEARED;
                     state_in      = S_RESP;
                  end
                  KIND_READ: begin
                     if (CMPW'(cmd.read_index) < CMPW'(count_ff)) begin
                        idx_in   = AW'(cmd.read_index);
                        state_in = S_RD_WAIT;
                     end else begin
                        res_in.status = ST_BAD_INDEX;
                        state_in      = S_RESP;
                     end
                  end
                  KIND_OFFER: begin
                     idx_in       = '0;
                     ins_found_in = 1'b0;
                     state_in     = cfg.radius_check_enable ? S_RAD_ABS : S_SC_RD;
                  end
                  default: begin
                     res_in.status = ST_BAD_INDEX;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            res_in.status = ST_READ;
            res_in.slot   = low6(idx_ff);
            res_in.entry  = rdata_ff;
            state_in      = S_RESP;
         end
         S_RAD_ABS: state_in = S_RAD_SQ;
         S_RAD_SQ:  state_in = S_RAD_SUM;
         S_RAD_SUM: state_in = S_RAD_CMP;
         S_RAD_CMP: begin
            if (d_ff > 34'(cfg.limit_radius_sq)) begin
               res_in.status = ST_OUTSIDE;
               state_in      = S_RESP;
            end else begin
               state_in = S_SC_RD;
            end
         end
         S_SC_RD: begin
            if (idx_ff < count_ff) begin
               state_in = S_SC_ABS;
            end else begin
               if (!ins_found_ff) begin
                  ins_in = count_ff;
               end
               state_in = S_DECIDE;
            end
         end
         S_SC_ABS: begin
            ent_in = rdata_ff;
            if (!ins_found_ff && (rdata_ff.integrated < cmd_ff.integrated)) begin
               ins_found_in = 1'b1;
               ins_in       = idx_ff;
            end
            state_in = S_SC_SQ;
         end
         S_SC_SQ:  state_in = S_SC_SUM;
         S_SC_SUM: state_in = S_SC_CMP;
         S_SC_CMP: begin
            if (d_ff < close_thr) begin
               res_in.slot  = low6(idx_ff);
               res_in.entry = ent_ff;
               if (d_ff >= ONE_PIXEL_SQ) begin
                  res_in.status = ST_NEAR;
                  state_in      = S_RESP;
               end else if (ent_ff.hits != HITS_MAX) begin
                  mg_in    = ent_ff;
                  fld_in   = 2'd0;
                  state_in = S_MG_MUL;
               end else begin
                  res_in.status = ST_MERGED;
                  state_in      = S_RESP;
               end
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_SC_RD;
            end
         end
         S_MG_MUL: begin
            mul_in   = 48'(old_sel) * 48'(ent_ff.hits);
            state_in = S_MG_DIV;
         end
         S_MG_DIV: begin
            div_start = 1'b1;
            state_in  = S_MG_WAIT;
         end
         S_MG_WAIT: begin
            if (div_done) begin
               case (fld_ff)
                  2'd0:    mg_in.x          = div_quo[15:0];
                  2'd1:    mg_in.y          = div_quo[15:0];
                  2'd2:    mg_in.amplitude  = div_quo[31:0];
                  default: mg_in.integrated = div_quo[31:0];
               endcase
               if (fld_ff == 2'd3) begin
                  mg_in.hits = ent_ff.hits + 16'd1;
                  state_in   = S_MG_WRITE;
               end else begin
                  fld_in   = fld_ff + 2'd1;
                  state_in = S_MG_MUL;
               end
            end
         end
         S_MG_WRITE: begin
            we            = 1'b1;
            wdata         = mg_ff;
            res_in.status = ST_MERGED;
            res_in.slot   = low6(idx_ff);
            res_in.entry  = mg_ff;
            state_in      = S_RESP;
         end
         S_DECIDE: begin
            if ((ins_ff == count_ff) && (count_ff == LAST)) begin
               res_in.status = ST_FULL;
               state_in      = S_RESP;
            end else begin
               idx_in   = (count_ff < LAST) ? count_ff : count_ff - AW'(1);
               state_in = S_SH_RD;
            end
         end
         S_SH_RD: begin
            raddr = idx_ff - AW'(1);
            if (idx_ff > ins_ff) begin
               state_in = S_SH_WR;
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_SH_WR: begin
            we       = 1'b1;
            idx_in   = idx_ff - AW'(1);
            state_in = S_SH_RD;
         end
         S_INS_WR: begin
            we    = 1'b1;
            waddr = ins_ff;
            wdata = new_entry;
            if (count_ff < LAST) begin
               count_in = count_ff + AW'(1);
            end
            res_in.status = ST_INSERTED;
            res_in.slot   = low6(ins_ff);
            res_in.entry  = new_entry;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (!out_valid_ff || rsp_pop) begin
               out_in            = res_ff;
               out_in.peak_count = low6(count_ff);
               out_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      ins_ff       <= ins_in;
      ins_found_ff <= ins_found_in;
      ent_ff       <= ent_in;
      mg_ff        <= mg_in;
      fld_ff       <= fld_in;
      mul_ff       <= mul_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      d_ff         <= d_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         table_mem[waddr] <= wdata;
      end
      rdata_ff <= table_mem[raddr];
   end

   assign rsp       = out_ff;
   assign rsp_valid = out_valid_ff;

endmodule

[rtl/peak_merge_sorted_table_core.sv]
// Top level of the peak merge sorted table: registers, front end and engine.
// Depends on pmst_pkg, pmst_front and pmst_engine.
//
// Input words enter through req_push/req_full; req_mode selects offer, read
// or clear. Results leave through rsp_empty/rsp_pop, one word per input word,
// in order. A two word command queue lets the front accept words while the
// engine works, and the result register holds a finished word until it is
// popped; the engine waits in its response step while that register is full.
// Clear, bad mode and bad index go from the idle step to the response step,
// a read through a memory wait step. An offer runs the radius check steps
// when enabled, then per table entry scanned a memory read and the pipelined
// distance square, then either a merge of four fields through the one bit
// per cycle divider, or an insert that shifts each later entry down with a
// memory read and write. Synchronous reset empties both queues and the table
// (count zero); no clearing pass is needed. Configuration registers are
// written by csr_write_enable, csr_index and csr_write_data; the user must
// write them only while the block is idle; the block does not enforce it.
module peak_merge_sorted_table_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_peak_x,
   input  logic [15:0] req_peak_y,
   input  logic [31:0] req_peak_amplitude,
   input  logic [31:0] req_peak_integrated,
   input  logic [5:0]  req_read_index,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_slot,
   output logic [5:0]  rsp_peak_count,
   output logic [15:0] rsp_entry_x,
   output logic [15:0] rsp_entry_y,
   output logic [31:0] rsp_entry_amplitude,
   output logic [31:0] rsp_entry_integrated,
   output logic [15:0] rsp_entry_hits,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [32:0] csr_write_data
);
   import pmst_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   logic       cmd_valid, cmd_pop, rsp_valid;
   result_type rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CENTER_X:      cfg_in.center_x            = csr_write_data[15:0];
            CSR_CENTER_Y:      cfg_in.center_y            = csr_write_data[15:0];
            CSR_LIMIT_RADIUS:  cfg_in.limit_radius_sq     = csr_write_data;
            CSR_RADIUS_ENABLE: cfg_in.radius_check_enable = csr_write_data[0];
            CSR_WINDOW_RADIUS: cfg_in.window_radius       = csr_write_data[7:0];
            default:           cfg_in                     = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x            <= 16'd0;
         cfg_ff.center_y            <= 16'd0;
         cfg_ff.limit_radius_sq     <= 33'd0;
         cfg_ff.radius_check_enable <= 1'b0;
         cfg_ff.window_radius       <= 8'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pmst_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .mode           (req_mode),
      .peak_x         (req_peak_x),
      .peak_y         (req_peak_y),
      .peak_amplitude (req_peak_amplitude),
      .peak_integrated(req_peak_integrated),
      .read_index     (req_read_index),
      .full           (req_full),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop)
   );

   pmst_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .cmd_valid(cmd_valid),
      .cmd_pop  (cmd_pop),
      .rsp      (rsp),
      .rsp_valid(rsp_valid),
      .rsp_pop  (rsp_pop)
   );

   assign rsp_empty            = !rsp_valid;
   assign rsp_status           = rsp.status;
   assign rsp_slot             = rsp.slot;
   assign rsp_peak_count       = rsp.peak_count;
   assign rsp_entry_x          = rsp.entry.x;
   assign rsp_entry_y          = rsp.entry.y;
   assign rsp_entry_amplitude  = rsp.entry.amplitude;
   assign rsp_entry_integrated = rsp.entry.integrated;
   assign rsp_entry_hits       = rsp.entry.hits;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result word present after reset");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == 3'(ST_CLEARED)) |-> (rsp_peak_count == 6'd0 && rsp_slot == 6'd0))
      else $error("clear word reports a nonzero count or slot");

   a_insert_hits: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == 3'(ST_INSERTED)) |-> (rsp_entry_hits == 16'd1))
      else $error("inserted entry does not report one hit");

   a_drop_blank: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status == 3'(ST_OUTSIDE) || rsp_status == 3'(ST_FULL)))
      |-> (rsp_slot == 6'd0 && rsp_entry_hits == 16'd0))
      else $error("dropped peak reports an entry");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for peak_merge_sorted_table_core: a directed table and random words,
// each checked against a behavioral model of the sorted peak table. Depends on pmst_pkg.
module tb_top;
   import pmst_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot;
      logic [5:0]  peak_count;
      logic [15:0] x;
      logic [15:0] y;
      logic [31:0] amplitude;
      logic [31:0] integrated;
      logic [15:0] hits;
   } answer_type;

   typedef struct {
      logic [1:0]  mode;
      logic [15:0] px;
      logic [15:0] py;
      logic [31:0] pa;
      logic [31:0] pi;
      logic [5:0]  ri;
      bit          typed;
      answer_type  want;
   } stim_row_type;

   localparam int DEPTH = 64;
   localparam longint CYCLE_LIMIT = 3000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [1:0]  req_mode = MODE_OFFER;
   logic [15:0] req_peak_x = 0;
   logic [15:0] req_peak_y = 0;
   logic [31:0] req_peak_amplitude = 0;
   logic [31:0] req_peak_integrated = 0;
   logic [5:0]  req_read_index = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_slot;
   logic [5:0]  rsp_peak_count;
   logic [15:0] rsp_entry_x;
   logic [15:0] rsp_entry_y;
   logic [31:0] rsp_entry_amplitude;
   logic [31:0] rsp_entry_integrated;
   logic [15:0] rsp_entry_hits;
   logic        csr_write_enable = 0;
   logic [2:0]  csr_index = CSR_CENTER_X;
   logic [32:0] csr_write_data = 0;

   peak_merge_sorted_table_core uut (.*);

   always #10 clock = ~clock;

   logic [15:0] tab_x [DEPTH];
   logic [15:0] tab_y [DEPTH];
   logic [31:0] tab_a [DEPTH];
   logic [31:0] tab_i [DEPTH];
   logic [15:0] tab_h [DEPTH];
   int unsigned held;
   logic [15:0] cen_x, cen_y;
   logic [32:0] lim_sq;
   logic        lim_on;
   logic [7:0]  win_r;

   answer_type pending_answers [$];
   int      errors = 0;
   longint  cycles = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   function automatic logic [33:0] span_sq(logic [15:0] ax, ay, bx, by);
      logic [33:0] dx, dy;
      dx = (ax > bx) ? 34'(ax - bx) : 34'(bx - ax);
      dy = (ay > by) ? 34'(ay - by) : 34'(by - ay);
      return dx * dx + dy * dy;
   endfunction

   function automatic logic [31:0] run_mean(logic [31:0] old, logic [15:0] n, logic [31:0] v);
      logic [63:0] num;
      num = 64'(old) * 64'(n) + 64'(v);
      return 32'(num / (64'(n) + 64'd1));
   endfunction

   function automatic answer_type make_answer(status_type st, int s, bit show);
      answer_type r;
      r = '0;
      r.status = st;
      r.slot = 6'(s);
      r.peak_count = 6'(held);
      if (show) begin
         r.x = tab_x[s]; r.y = tab_y[s]; r.amplitude = tab_a[s];
         r.integrated = tab_i[s]; r.hits = tab_h[s];
      end
      return r;
   endfunction

   function automatic answer_type table_step(logic [1:0] mode, logic [15:0] px, py,
                                             logic [31:0] pa, pi, logic [5:0] ri);
      int l, i, j;
      logic [33:0] d, thr;
      logic [15:0] n, half;
      d = 0;
      if (mode == MODE_CLEAR) begin
         held = 0;
         return make_answer(ST_CLEARED, 0, 0);
      end
      if (mode == MODE_READ)
         return (ri < held) ? make_answer(ST_READ, ri, 1) : make_answer(ST_BAD_INDEX, 0, 0);
      if (mode != MODE_OFFER) return make_answer(ST_BAD_INDEX, 0, 0);
      if (lim_on && span_sq(px, py, cen_x, cen_y) > 34'(lim_sq))
         return make_answer(ST_OUTSIDE, 0, 0);
      half = 16'(win_r >> 1);
      thr = 34'(half * half) << 8;
      for (l = 0; l < held; l++) begin
         d = span_sq(tab_x[l], tab_y[l], px, py);
         if (d < thr) break;
      end
      if (l < held) begin
         if (d >= ONE_PIXEL_SQ) return make_answer(ST_NEAR, l, 1);
         if (tab_h[l] < HITS_MAX) begin
            n = tab_h[l];
            tab_x[l] = 16'(run_mean(32'(tab_x[l]), n, 32'(px)));
            tab_y[l] = 16'(run_mean(32'(tab_y[l]), n, 32'(py)));
            tab_a[l] = run_mean(tab_a[l], n, pa);
            tab_i[l] = run_mean(tab_i[l], n, pi);
            tab_h[l] = n + 16'd1;
         end
         return make_answer(ST_MERGED, l, 1);
      end
      for (i = 0; i < held; i++)
         if (tab_i[i] < pi) break;
      if (i == held && held >= DEPTH - 1) return make_answer(ST_FULL, 0, 0);
      j = (held < DEPTH - 1) ? held : held - 1;
      for (; j > i; j--) begin
         tab_x[j] = tab_x[j-1]; tab_y[j] = tab_y[j-1]; tab_a[j] = tab_a[j-1];
         tab_i[j] = tab_i[j-1]; tab_h[j] = tab_h[j-1];
      end
      tab_x[i] = px; tab_y[i] = py; tab_a[i] = pa; tab_i[i] = pi; tab_h[i] = 16'd1;
      if (held < DEPTH - 1) held++;
      return make_answer(ST_INSERTED, i, 1);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // Result side: random stalls, compare with the oldest expectation.
   always @(posedge clock) begin
      answer_type g, w;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            g = {rsp_status, rsp_slot, rsp_peak_count, rsp_entry_x, rsp_entry_y,
                 rsp_entry_amplitude, rsp_entry_integrated, rsp_entry_hits};
            if (pending_answers.size() == 0) report_mismatch("unexpected word", g[63:0], 0);
            else begin
               w = pending_answers.pop_front();
               if (g.status != w.status) report_mismatch("status", g.status, w.status);
               if (g.slot != w.slot) report_mismatch("slot", g.slot, w.slot);
               if (g.peak_count != w.peak_count)
                  report_mismatch("peak_count", g.peak_count, w.peak_count);
               if (g.x != w.x) report_mismatch("entry_x", g.x, w.x);
               if (g.y != w.y) report_mismatch("entry_y", g.y, w.y);
               if (g.amplitude != w.amplitude)
                  report_mismatch("entry_amplitude", g.amplitude, w.amplitude);
               if (g.integrated != w.integrated)
                  report_mismatch("entry_integrated", g.integrated, w.integrated);
               if (g.hits != w.hits) report_mismatch("entry_hits", g.hits, w.hits);
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic push_word(logic [1:0] mode, logic [15:0] px, py, logic [31:0] pa, pi,
                            logic [5:0] ri, bit typed, answer_type want);
      answer_type a;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(posedge clock);
      end
      req_push <= 1;
      req_mode <= mode; req_peak_x <= px; req_peak_y <= py;
      req_peak_amplitude <= pa; req_peak_integrated <= pi; req_read_index <= ri;
      @(posedge clock);
      while (req_full) @(posedge clock);
      a = table_step(mode, px, py, pa, pi, ri);
      if (typed && a != want) report_mismatch("directed row", a[63:0], want[63:0]);
      pending_answers.insert(pending_answers.size(), a);
   endtask

   task automatic drain();
      req_push <= 0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [32:0] val);
      csr_write_enable <= 1; csr_index <= idx; csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         CSR_CENTER_X:      cen_x = val[15:0];
         CSR_CENTER_Y:      cen_y = val[15:0];
         CSR_LIMIT_RADIUS:  lim_sq = val;
         CSR_RADIUS_ENABLE: lim_on = val[0];
         CSR_WINDOW_RADIUS: win_r = val[7:0];
         default: ;
      endcase
   endtask

   task automatic random_offer(int cluster);
      logic [15:0] bx, by;
      int k;
      k = $urandom_range(cluster - 1);
      if ($urandom_range(9) < 7) begin
         bx = 16'(2000 + k * 700) + 16'($urandom_range(40));
         by = 16'(3000 + k * 500) + 16'($urandom_range(40));
      end else begin
         bx = 16'($urandom); by = 16'($urandom);
      end
      push_word(MODE_OFFER, bx, by, $urandom, ($urandom_range(3) == 0) ? 32'(k * 1000) : $urandom,
                6'($urandom), 0, '0);
   endtask

   task automatic random_word();
      int r;
      r = $urandom_range(99);
      if (r < 80) random_offer(70);
      else if (r < 95) push_word(MODE_READ, 16'($urandom), 16'($urandom), $urandom, $urandom,
                                 (r & 1) ? 6'($urandom_range(held)) : 6'($urandom), 0, '0);
      else if (r < 97) push_word(MODE_CLEAR, 16'($urandom), 16'($urandom), $urandom, $urandom,
                                 6'($urandom), 0, '0);
      else push_word(2'd3, 16'($urandom), 16'($urandom), $urandom, $urandom, 6'($urandom),
                     0, '0);
   endtask

   stim_row_type dir_rows [] = '{
      '{MODE_READ, 0, 0, 0, 0, 6'd0, 1, '{ST_BAD_INDEX, 0, 0, 0, 0, 0, 0, 0}},
      '{MODE_OFFER, 16'h0000, 16'h0000, 32'h0, 32'h0, 0, 1,
        '{ST_INSERTED, 0, 1, 16'h0000, 16'h0000, 32'h0, 32'h0, 16'd1}},
      '{MODE_OFFER, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1,
        '{ST_INSERTED, 0, 2, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd1}},
      '{MODE_OFFER, 16'hFFF8, 16'hFFFF, 32'h1, 32'hFFFFFFFF, 0, 0, '0},
      '{MODE_OFFER, 16'hFF00, 16'hFFFF, 32'h5, 32'h5, 0, 0, '0},
      '{MODE_OFFER, 16'h1000, 16'h1000, 32'h10, 32'h5, 0, 0, '0},
      '{MODE_OFFER, 16'h8000, 16'h4000, 32'h10, 32'h0, 0, 0, '0},
      '{MODE_READ, 0, 0, 0, 0, 6'd1, 0, '0},
      '{MODE_READ, 0, 0, 0, 0, 6'd63, 1, '{ST_BAD_INDEX, 0, 5, 0, 0, 0, 0, 0}},
      '{2'd3, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 6'd63, 1,
        '{ST_BAD_INDEX, 0, 5, 0, 0, 0, 0, 0}},
      '{MODE_CLEAR, 16'h5555, 16'hAAAA, 32'h55555555, 32'hAAAAAAAA, 6'd21, 1,
        '{ST_CLEARED, 0, 0, 0, 0, 0, 0, 0}},
      '{MODE_READ, 0, 0, 0, 0, 6'd0, 1, '{ST_BAD_INDEX, 0, 0, 0, 0, 0, 0, 0}}
   };

   initial begin
      int ph, n;
      held = 0; cen_x = 0; cen_y = 0; lim_sq = 0; lim_on = 0; win_r = 16;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (dir_rows[k])
         push_word(dir_rows[k].mode, dir_rows[k].px, dir_rows[k].py, dir_rows[k].pa,
                   dir_rows[k].pi, dir_rows[k].ri, dir_rows[k].typed, dir_rows[k].want);
      drain();
      // Radius check on, tight limit around a chosen center.
      write_reg(CSR_CENTER_X, 33'h8000);
      write_reg(CSR_CENTER_Y, 33'h8000);
      write_reg(CSR_LIMIT_RADIUS, 33'd65536);
      write_reg(CSR_RADIUS_ENABLE, 33'd1);
      push_word(MODE_OFFER, 16'h8000, 16'h8000, 32'd7, 32'd7, 0, 0, '0);
      push_word(MODE_OFFER, 16'h8100, 16'h8000, 32'd7, 32'd7, 0, 0, '0);
      push_word(MODE_OFFER, 16'h8200, 16'h8000, 32'd7, 32'd7, 0, 1,
                '{ST_OUTSIDE, 0, 2, 0, 0, 0, 0, 0});
      drain();
      write_reg(CSR_WINDOW_RADIUS, 33'd0);
      push_word(MODE_OFFER, 16'h8000, 16'h8000, 32'd9, 32'd9, 0, 0, '0);
      drain();
      write_reg(CSR_LIMIT_RADIUS, 33'h1FFFFFFFF);
      write_reg(CSR_WINDOW_RADIUS, 33'd255);
      push_word(MODE_OFFER, 16'h9000, 16'h8000, 32'd9, 32'd9, 0, 0, '0);
      drain();
      write_reg(CSR_RADIUS_ENABLE, 33'd0);
      write_reg(CSR_CENTER_X, 33'h0);
      write_reg(CSR_CENTER_Y, 33'hFFFF);
      write_reg(CSR_WINDOW_RADIUS, 33'd16);
      push_word(MODE_CLEAR, 0, 0, 0, 0, 0, 0, '0);
      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            3: begin send_idle_pct = 24; recv_stall_pct = 24; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         // Fill the table past capacity once so full handling is reached.
         if (ph == 4)
            for (n = 0; n < 70; n++)
               push_word(MODE_OFFER, 16'(n * 1000), 16'(n * 900), $urandom,
                         32'($urandom_range(200)), 0, 0, '0);
         for (n = 0; n < 64; n++) begin
            random_word();
            if (n == 32) drain();
         end
         drain();
         if (ph == 1) write_reg(CSR_WINDOW_RADIUS, 33'($urandom_range(4, 60)));
         if (ph == 2) begin
            write_reg(CSR_RADIUS_ENABLE, 33'd1);
            write_reg(CSR_LIMIT_RADIUS, {1'b0, $urandom});
            write_reg(CSR_CENTER_X, 33'($urandom));
         end
         if (ph == 3) write_reg(CSR_RADIUS_ENABLE, 33'd0);
      end
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
